>>> hdl/sha_pkg.sv
// sha_pkg: shared types, constants and functions for the sha-256 hasher
// used by sha_ctrl, sha_dp and the top level; no dependencies
package sha_pkg;

  // where a pushed block byte comes from
  localparam logic [1:0] SRC_MSG  = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // commands from controller to datapath
  typedef struct packed {
    logic       push;     // append one byte to the block
    logic [1:0] src;      // byte source code
    logic       count;    // add 8 to the message bit count
    logic       load;     // copy chaining words into working vars
    logic       round;    // run one compression round
    logic [5:0] rnd;      // round index
    logic       fold;     // add working vars into chaining words
    logic [2:0] idx;      // length byte / digest word index
    logic       out_load; // load digest word into output register
    logic       reinit;   // back to initial hash, clear bit count
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [5:0] fill;     // bytes held in the current block
  } stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hdl/sha256_message_hasher_unit.sv
// sha256_message_hasher_unit: top level of the sha-256 byte stream hasher
// depends on sha_pkg, sha_ctrl, sha_dp
//
// usage:
//   input channel s_axis: one transaction per message byte; tuser says whether
//   tdata holds a byte, tlast ends the message after that byte (a transaction
//   with tuser low and tlast high ends a message, also an empty one)
//   output channel m_axis: eight transactions per message, digest words
//   h0..h7 in order, big-endian byte order inside a word, tlast on h7
// sequence:
//   a byte that does not fill the block leaves the sequencer idle for the next byte
//   a byte that fills the 64-byte block starts a compression: one load, 64 rounds
//   of the single round unit, one fold into the chaining words
//   end of message: the 0x80 byte, the zero pad bytes, a step to leave the
//   zero run, the 8 length bytes, a compression for each full block, then
//   the 8 digest words
//   s_axis takes no byte while a block is compressed or the message is padded
// reset: chaining words to the initial hash, bit count and fill cleared,
//   output channel empty; each digest restores chaining words and bit count
// stalls: the digest words wait in an output register; the sequencer holds
//   until each word is taken, and s_axis_tready is low until the last word
//   has been loaded into that register
module sha256_message_hasher_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast    // digest_last
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: intake, padding, round count, output handshake
  sha_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .stat          (stat)
  );

  // datapath: word line, schedule, round unit, chaining words, bit count
  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .msg_byte    (s_axis_tdata),
    .digest_word (m_axis_tdata),
    .digest_last (m_axis_tlast)
  );

endmodule

>>> hdl/sha_ctrl.sv
// sha_ctrl: sequencer for byte intake, padding, compression rounds and digest output
// depends on sha_pkg
module sha_ctrl import sha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  logic  s_axis_tuser,
  input  logic  s_axis_tlast,
  output logic  m_axis_tvalid,
  input  logic  m_axis_tready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_ROUND = 4'd2;
  localparam logic [3:0] S_FOLD  = 4'd3;
  localparam logic [3:0] S_PAD80 = 4'd4;
  localparam logic [3:0] S_ZERO  = 4'd5;
  localparam logic [3:0] S_LEN   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] cnt, cnt_next;
  logic       m_valid, m_valid_next;
  logic       last_slot;

  assign last_slot     = (stat.fill == 6'd63);
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    rnd_next     = rnd;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.rnd      = rnd;
    cmd.idx      = cnt;
    m_valid_next = m_valid && !m_axis_tready;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.push  = s_axis_tuser;
          cmd.src   = SRC_MSG;
          cmd.count = s_axis_tuser;
          if (s_axis_tuser && last_slot) begin
            state_next = S_LOAD;
            ret_next   = s_axis_tlast ? S_PAD80 : S_IDLE;
          end else if (s_axis_tlast) begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_PAD;
        if (last_slot) begin
          state_next = S_LOAD;
          ret_next   = S_ZERO;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat.fill == 6'd56) begin
          state_next = S_LEN;
          cnt_next   = '0;
        end else begin
          cmd.push = 1'b1;
          cmd.src  = SRC_ZERO;
          if (last_slot) begin
            state_next = S_LOAD;
            ret_next   = S_ZERO;
          end
        end
      end
      S_LEN: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_LEN;
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd7) begin
          state_next = S_LOAD;
          ret_next   = S_OUT;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        rnd_next   = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == 6'd63) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ret;
      end
      S_OUT: begin
        if (!m_valid || m_axis_tready) begin
          cmd.out_load = 1'b1;
          m_valid_next = 1'b1;
          cnt_next     = cnt + 3'd1;
          if (cnt == 3'd7) begin
            cmd.reinit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      rnd     <= '0;
      cnt     <= '0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      rnd     <= rnd_next;
      cnt     <= cnt_next;
      m_valid <= m_valid_next;
    end
  end

endmodule

>>> hdl/sha_dp.sv
// sha_dp: block word line, message schedule, round logic, chaining words, bit count
// depends on sha_pkg
module sha_dp import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  msg_byte,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  logic [31:0] hc [8];
  logic [31:0] v  [8];
  logic [31:0] w  [16];
  logic [23:0] acc;
  logic [63:0] message_bits;
  logic [5:0]  fill;
  logic [7:0]  blk_byte;
  logic [31:0] new_w, push_w;
  logic [31:0] t1, t2, big0, big1, choose, major, sig0, sig1;

  assign stat.fill = fill;

  always_comb begin
    case (cmd.src)
      SRC_MSG:  blk_byte = msg_byte;
      SRC_PAD:  blk_byte = 8'h80;
      SRC_ZERO: blk_byte = 8'h00;
      SRC_LEN:  blk_byte = message_bits[{~cmd.idx, 3'b000} +: 8];
      default:  blk_byte = 8'h00;
    endcase
  end

  assign push_w = {acc, blk_byte};

  // schedule: w[0] is the word for this round
  assign sig0  = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign sig1  = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign new_w = sig1 + w[9] + sig0 + w[0];

  assign big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1     = v[7] + big1 + choose + ROUND_K[cmd.rnd] + w[0];
  assign big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2     = big0 + major;

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      message_bits <= '0;
      for (int i = 0; i < 8; i++) hc[i] <= INIT_HASH[i];
    end else begin
      if (cmd.push) fill <= fill + 6'd1;
      if (cmd.count) message_bits <= message_bits + 64'd8;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hc[i] <= hc[i] + v[i];
      end
      if (cmd.reinit) begin
        message_bits <= '0;
        for (int i = 0; i < 8; i++) hc[i] <= INIT_HASH[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      acc <= push_w[23:0];
      if (fill[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= push_w;
      end
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= new_w;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v[i] <= hc[i];
    end
    if (cmd.out_load) begin
      digest_word <= hc[cmd.idx];
      digest_last <= (cmd.idx == 3'd7);
    end
  end

endmodule
